// ===== hdl/conditional_bitmask_rule_chain_top_assert.svh =====
// ----------------------------------------------------------------------------
// Rule chain assertion macros
// Shared property wrappers for the rule chain checkers.
// ----------------------------------------------------------------------------
`ifndef CONDITIONAL_BITMASK_RULE_CHAIN_TOP_ASSERT_SVH
`define CONDITIONAL_BITMASK_RULE_CHAIN_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CBRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, quiet during reset
`define CBRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/cbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rule chain package
// Command and operation codes, the rule word and the word that travels
// along the row of rule cells.
// ----------------------------------------------------------------------------
package cbrc_pkg;

   // command codes carried on req_tuser; code 3 is unused
   typedef enum logic [1:0] {
      CMD_PROCESS = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   // rule operations
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_OR   = 2'd1,
      OP_AND  = 2'd2,
      OP_XOR  = 2'd3
   } op_type;

   // one stored rule
   typedef struct packed {
      logic [2:0] track;
      op_type     op;
      logic [7:0] mask;
      logic       terminate;
   } rule_word_type;

   // word moving from cell to cell
   typedef struct packed {
      logic          process;  // run the chain on this word
      logic          load;     // append: rule goes into the cell at the slot
      logic          dropped;  // append found the table full
      logic [7:0]    src;
      logic [7:0]    res;
      rule_word_type rule;
   } item_type;

endpackage

// ===== hdl/conditional_bitmask_rule_chain_top.sv =====
// ----------------------------------------------------------------------------
// Conditional bitmask rule chain
// Ordered rule table held in a row of cells; appends, clears and byte
// processing share one stream.
// ----------------------------------------------------------------------------
// Every request word gives one response word. Words travel through a row of
// MAX_FILTERS registered rule cells, one cell per cycle, and a response leaves
// the last cell; a new request is taken every cycle while the response side
// keeps up; any stall on the response side holds the whole row. The rule
// count is kept at the entry, so an append or clear is settled as it is taken
// and later words see it in order. After reset the table is empty and no
// clearing pass is needed.
module conditional_bitmask_rule_chain_top
   import cbrc_pkg::*;
#(
   parameter int MAX_FILTERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // source_bits[7:0], rule_track[10:8], rule_op[12:11], rule_mask[20:13],
   // rule_terminate[21], zero pad[23:22]
   input  logic [23:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_bits[7:0], rule_count[12:8], chain_available[13],
   // append_dropped[14], zero pad[15]
   output logic [15:0] rsp_tdata
);

   localparam int CW = $clog2(MAX_FILTERS + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_FILTERS);

   logic          en;
   logic [CW-1:0] total_ff, total_in;
   item_type      front;
   cmd_type       cmd;

   item_type      stage_item  [MAX_FILTERS+1];
   logic          stage_valid [MAX_FILTERS+1];
   logic [CW-1:0] stage_count [MAX_FILTERS+1];
   logic [CW-1:0] stage_slot  [MAX_FILTERS+1];

   logic [CW+4:0] count_wide;

   // row advances unless the response word is stuck
   assign en         = !stage_valid[MAX_FILTERS] || rsp_tready;
   assign req_tready = en;
   assign cmd        = cmd_type'(req_tuser);

   // entry: decode the command and settle the rule count
   always_comb begin
      total_in          = total_ff;
      front.process     = (cmd == CMD_PROCESS);
      front.load        = 1'b0;
      front.dropped     = 1'b0;
      front.src         = req_tdata[7:0];
      front.res         = req_tdata[7:0];
      front.rule.track  = req_tdata[10:8];
      front.rule.op     = op_type'(req_tdata[12:11]);
      front.rule.mask   = req_tdata[20:13];
      front.rule.terminate = req_tdata[21];
      unique case (cmd)
         CMD_PROCESS: ;
         CMD_APPEND: begin
            if (total_ff < FULL) begin
               total_in   = CW'(total_ff + 1'b1);
               front.load = 1'b1;
            end else begin
               front.dropped = 1'b1;
            end
         end
         CMD_CLEAR: total_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (req_tvalid && en) begin
         total_ff <= total_in;
      end
   end

   assign stage_valid[0] = req_tvalid;
   assign stage_item[0]  = front;
   assign stage_count[0] = total_in;
   assign stage_slot[0]  = total_ff;

   // row of rule cells
   for (genvar k = 0; k < MAX_FILTERS; k++) begin : g_cell
      cbrc_cell #(
         .CELL_INDEX  (k),
         .COUNT_WIDTH (CW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (stage_valid[k]),
         .up_item  (stage_item[k]),
         .up_count (stage_count[k]),
         .up_slot  (stage_slot[k]),
         .dn_valid (stage_valid[k+1]),
         .dn_item  (stage_item[k+1]),
         .dn_count (stage_count[k+1]),
         .dn_slot  (stage_slot[k+1])
      );
   end

   // response packing; count wraps to five bits
   assign count_wide = {5'b0, stage_count[MAX_FILTERS]};
   assign rsp_tvalid = stage_valid[MAX_FILTERS];
   assign rsp_tdata  = {1'b0,
                        stage_item[MAX_FILTERS].dropped,
                        (stage_count[MAX_FILTERS] != '0),
                        count_wide[4:0],
                        stage_item[MAX_FILTERS].res};

endmodule

// ===== hdl/cbrc_cell.sv =====
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule of the chain. Applies it to a passing process word, or
// takes a new rule from a passing append word aimed at this slot.
// ----------------------------------------------------------------------------
module cbrc_cell
   import cbrc_pkg::*;
#(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   up_valid,
   input  item_type               up_item,
   input  logic [COUNT_WIDTH-1:0] up_count,
   input  logic [COUNT_WIDTH-1:0] up_slot,
   output logic                   dn_valid,
   output item_type               dn_item,
   output logic [COUNT_WIDTH-1:0] dn_count,
   output logic [COUNT_WIDTH-1:0] dn_slot
);

   localparam logic [COUNT_WIDTH-1:0] MY_SLOT = COUNT_WIDTH'(CELL_INDEX);

   rule_word_type          rule_ff, rule_in;
   logic                   valid_ff;
   item_type               item_ff, item_in;
   logic [COUNT_WIDTH-1:0] count_ff, slot_ff;

   // rule load from an append word for this slot
   always_comb begin
      rule_in = rule_ff;
      if (up_valid && up_item.load && (up_slot == MY_SLOT)) begin
         rule_in = up_item.rule;
      end
   end

   // apply this rule when it is within the held count
   always_comb begin
      logic [7:0] res_v;
      logic [7:0] src_v;
      item_in = up_item;
      res_v   = up_item.res;
      src_v   = up_item.src;
      if (up_item.process && (up_count > MY_SLOT)) begin
         if (up_item.src[rule_ff.track]) begin
            case (rule_ff.op)
               OP_OR:   res_v = up_item.src | rule_ff.mask;
               OP_AND:  res_v = up_item.src & rule_ff.mask;
               OP_XOR:  res_v = up_item.src ^ rule_ff.mask;
               default: res_v = up_item.res;
            endcase
         end
         if (rule_ff.terminate) begin
            src_v = res_v;
         end
      end
      item_in.res = res_v;
      item_in.src = src_v;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // payload and rule storage
   always_ff @(posedge clock) begin
      if (en) begin
         item_ff  <= item_in;
         count_ff <= up_count;
         slot_ff  <= up_slot;
         rule_ff  <= rule_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;
   assign dn_count = count_ff;
   assign dn_slot  = slot_ff;

endmodule

// ===== hdl/cbrc_checker.sv =====
// ----------------------------------------------------------------------------
// Rule chain checker
// Port-level checks of the rule chain, bound to the top level.
// ----------------------------------------------------------------------------
`include "conditional_bitmask_rule_chain_top_assert.svh"

module cbrc_checker #(
   parameter int MAX_FILTERS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   localparam logic [4:0] FULL_COUNT = 5'(MAX_FILTERS % 32);

   // stalled response holds
   `CBRC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CBRC_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // an empty output stage never blocks the request side
   `CBRC_ASSERT_NOW(a_req_open, !rsp_tvalid, req_tready)

   // a dropped append only happens on a full table
   `CBRC_ASSERT_NOW(a_drop_full, rsp_tvalid && rsp_tdata[14],
                    (rsp_tdata[12:8] == FULL_COUNT) && rsp_tdata[13])

endmodule

bind conditional_bitmask_rule_chain_top cbrc_checker #(
   .MAX_FILTERS (MAX_FILTERS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_conditional_bitmask_rule_chain_top.sv =====
// ----------------------------------------------------------------------------
// Rule chain testbench
// Streams appends, clears, unused codes and byte runs into the rule chain.
// It keeps its own copy of the rule table, computes the response word for
// every request at the input handshake, and compares each response field by
// field in order. Both sides idle at random, with calm stretches between.
// ----------------------------------------------------------------------------
module tb_conditional_bitmask_rule_chain_top
   import cbrc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FILTERS = 16;
   localparam int RANDOM_WORDS = 500;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // one request word as the block sees it
   typedef struct {
      logic [1:0]    command;
      logic [7:0]    source;
      rule_word_type rule;
   } request_type;

   // one response word
   typedef struct {
      logic [7:0] result_bits;
      logic [4:0] rule_count;
      logic       chain_available;
      logic       append_dropped;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   conditional_bitmask_rule_chain_top #(
      .MAX_FILTERS(MAX_FILTERS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   request_type   pending_words[$];
   response_type  expected_words[$];

   // shadow rule table
   rule_word_type chain_rules[MAX_FILTERS];
   int            chain_len = 0;

   int fail_count = 0;
   int words_total = 0;
   int words_taken = 0;
   int rsp_checked = 0;
   int n_process = 0;
   int n_append = 0;
   int n_dropped = 0;
   int n_clear = 0;
   int n_unused = 0;
   int cycle_count = 0;

   // compute the response for one request and update the shadow table
   function automatic response_type predict_rule_chain(request_type w);
      response_type r;
      logic [7:0]   src;
      logic [7:0]   res;
      logic         dropped;
      dropped = 1'b0;
      res = w.source;
      src = w.source;
      if (w.command == CMD_PROCESS) begin
         n_process++;
         for (int i = 0; i < chain_len; i++) begin
            if (src[chain_rules[i].track]) begin
               case (chain_rules[i].op)
                  OP_OR:   res = src | chain_rules[i].mask;
                  OP_AND:  res = src & chain_rules[i].mask;
                  OP_XOR:  res = src ^ chain_rules[i].mask;
                  default: ;
               endcase
            end
            // terminate hands the current result to later rules
            if (chain_rules[i].terminate)
               src = res;
         end
      end else if (w.command == CMD_APPEND) begin
         n_append++;
         if (chain_len < MAX_FILTERS) begin
            chain_rules[chain_len] = w.rule;
            chain_len++;
         end else begin
            dropped = 1'b1;
            n_dropped++;
         end
      end else if (w.command == CMD_CLEAR) begin
         n_clear++;
         chain_len = 0;
      end else begin
         n_unused++;
      end
      r.result_bits = res;
      r.rule_count = 5'(chain_len);
      r.chain_available = (chain_len > 0);
      r.append_dropped = dropped;
      return r;
   endfunction

   function automatic request_type make_word(logic [1:0] cmd, logic [7:0] src,
                                             logic [2:0] track, op_type op,
                                             logic [7:0] mask, logic term);
      request_type w;
      w.command = cmd;
      w.source = src;
      w.rule.track = track;
      w.rule.op = op;
      w.rule.mask = mask;
      w.rule.terminate = term;
      return w;
   endfunction

   // every field random apart from the command
   function automatic request_type random_word(logic [1:0] cmd);
      return make_word(cmd, 8'($urandom), 3'($urandom), op_type'($urandom_range(0, 3)),
                       8'($urandom), 1'($urandom));
   endfunction

   // idle cycles for the next word; none during a calm stretch
   function automatic int draw_wait(logic calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   request_type req_word;
   logic        req_busy = 1'b0;
   logic        req_calm = 1'b0;
   int          req_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_busy = 1'b0;
         req_wait = $urandom_range(0, 19);
      end else begin
         if (req_tvalid && req_tready) begin
            expected_words.push_back(predict_rule_chain(req_word));
            words_taken++;
            req_busy = 1'b0;
            req_wait = draw_wait(req_calm);
            if ($urandom_range(0, 39) == 0)
               req_calm = !req_calm;
         end
         if (!req_busy) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_words.size() > 0) begin
               req_word = pending_words.pop_front();
               req_busy = 1'b1;
               req_tdata <= {2'b00, req_word.rule.terminate, req_word.rule.mask,
                             req_word.rule.op, req_word.rule.track, req_word.source};
               req_tuser <= req_word.command;
            end
         end
         req_tvalid <= req_busy;
      end
   end

   // response monitor
   response_type rsp_want;
   logic         rsp_calm = 1'b0;
   int           rsp_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = $urandom_range(0, 19);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("response word 0x%h with nothing expected", rsp_tdata);
               fail_count++;
            end else begin
               rsp_want = expected_words.pop_front();
               rsp_checked++;
               check_field("result_bits", rsp_want.result_bits, rsp_tdata[7:0]);
               check_field("rule_count", rsp_want.rule_count, rsp_tdata[12:8]);
               check_field("chain_available", rsp_want.chain_available, rsp_tdata[13]);
               check_field("append_dropped", rsp_want.append_dropped, rsp_tdata[14]);
            end
            rsp_wait = draw_wait(rsp_calm);
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_words.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int n_directed;
      int n_rules;

      // directed: empty table, unused code, full table, drop, clear
      pending_words.push_back(make_word(CMD_PROCESS, 8'hA5, 3'd0, OP_NONE, 8'h00, 1'b0));
      pending_words.push_back(make_word(CMD_UNUSED, 8'hFF, 3'd7, OP_XOR, 8'hFF, 1'b1));
      for (int i = 0; i < MAX_FILTERS; i++) begin
         pending_words.push_back(make_word(CMD_APPEND, 8'($urandom), 3'(i % 8),
                                           op_type'(i % 4),
                                           (i == 0) ? 8'h00 :
                                           (i == MAX_FILTERS - 1) ? 8'hFF : 8'($urandom),
                                           1'((i >> 1) & 1)));
      end
      pending_words.push_back(make_word(CMD_PROCESS, 8'hFF, 3'd0, OP_NONE, 8'h00, 1'b0));
      pending_words.push_back(make_word(CMD_PROCESS, 8'h00, 3'd7, OP_XOR, 8'hFF, 1'b1));
      pending_words.push_back(make_word(CMD_PROCESS, 8'h5A, 3'd0, OP_OR, 8'h00, 1'b0));
      pending_words.push_back(make_word(CMD_APPEND, 8'hFF, 3'd7, OP_XOR, 8'hFF, 1'b1));
      pending_words.push_back(make_word(CMD_UNUSED, 8'h00, 3'd0, OP_NONE, 8'h00, 1'b0));
      pending_words.push_back(make_word(CMD_CLEAR, 8'h81, 3'd7, OP_AND, 8'hFF, 1'b1));
      pending_words.push_back(make_word(CMD_PROCESS, 8'h3C, 3'd2, OP_OR, 8'hFF, 1'b1));
      n_directed = pending_words.size();

      // random: mostly clear, load a chain, run bytes through it; some noise
      while (pending_words.size() < n_directed + RANDOM_WORDS) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 3) != 0)
               pending_words.push_back(random_word(CMD_CLEAR));
            n_rules = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20)
                                                  : $urandom_range(0, 6);
            repeat (n_rules) pending_words.push_back(random_word(CMD_APPEND));
            repeat ($urandom_range(1, 8)) pending_words.push_back(random_word(CMD_PROCESS));
         end else begin
            pending_words.push_back(random_word(2'($urandom_range(0, 3))));
         end
      end
      words_total = pending_words.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain, then give the row time to show any stray word
      while (words_taken < words_total || expected_words.size() != 0)
         @(negedge clock);
      repeat (2 * MAX_FILTERS + 10) @(posedge clock);

      $display("%0d words: %0d byte runs, %0d appends (%0d hit a full table), %0d clears,",
               words_taken, n_process, n_append, n_dropped, n_clear);
      $display("%0d unused codes; %0d responses checked field by field", n_unused,
               rsp_checked);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
